@@ rtl/hashed_context_cache_assert.svh @@
// assertion macros for the hashed context cache
// needs clk and rst in the scope of each use
`ifndef HASHED_CONTEXT_CACHE_ASSERT_SVH
`define HASHED_CONTEXT_CACHE_ASSERT_SVH

// consequent in the same cycle
`define HCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the next cycle
`define HCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hcc_pkg.sv @@
// shared constants, codes and controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hcc_pkg;
  localparam int SETS     = 16;
  localparam int WAYS     = 8;
  localparam int CONTEXTS = 128;
  localparam int ITEMS    = SETS * WAYS;

  localparam int SET_W  = $clog2(SETS);
  localparam int WAY_W  = $clog2(WAYS);
  localparam int ITEM_W = $clog2(ITEMS);
  localparam int CTX_W  = $clog2(CONTEXTS);
  localparam int IDX_W  = (ITEM_W > CTX_W) ? ITEM_W : CTX_W;

  localparam int CMD_W   = 2;
  localparam int COLOR_W = 8;
  localparam int PIX_W   = 32;
  localparam int SCR_W   = 3;
  localparam int FN_W    = 4;
  localparam int FONT_W  = 29;
  localparam int USERS_W = 16;
  localparam int HITS_W  = 32;

  localparam logic [CMD_W-1:0] CMD_FIND    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PURGE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  // item store read address select
  localparam logic [1:0] ISEL_SLOT = 2'd0;
  localparam logic [1:0] ISEL_REL  = 2'd1;
  localparam logic [1:0] ISEL_IDX  = 2'd2;

  typedef struct packed {
    logic             load;
    logic             slot_re;
    logic             slot_we;
    logic             slot_wsel_it;
    logic [WAY_W-1:0] slot_way;
    logic             latch_it;
    logic             latch_pv;
    logic             item_re;
    logic [1:0]       item_sel;
    logic             ctx_re;
    logic             ctx_sel_idx;
    logic [IDX_W-1:0] idx;
    logic             hit_wr;
    logic             alloc_fill;
    logic             reuse_fill;
    logic             rel_wr;
    logic             purge_chk;
    logic             finish;
    logic             fault;
  } dp_cmd_t;

  typedef struct packed {
    logic has_ctx;
    logic match;
    logic reuse_ok;
    logic free;
    logic promote;
    logic rel_ok;
  } dp_status_t;
endpackage
`default_nettype wire

@@ rtl/hcc_datapath.sv @@
// datapath: request registers, slot/item/context stores, result registers
// depends on hcc_pkg
`timescale 1ns / 1ps
`default_nettype none
module hcc_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire hcc_pkg::dp_cmd_t           cmd,
  output hcc_pkg::dp_status_t             status,
  input  wire logic [hcc_pkg::COLOR_W-1:0] red,
  input  wire logic [hcc_pkg::COLOR_W-1:0] green,
  input  wire logic [hcc_pkg::COLOR_W-1:0] blue,
  input  wire logic [hcc_pkg::PIX_W-1:0]  pixel_value,
  input  wire logic [hcc_pkg::SCR_W-1:0]  screen_number,
  input  wire logic [hcc_pkg::FN_W-1:0]   draw_function,
  input  wire logic                       subwin_clip,
  input  wire logic [hcc_pkg::FONT_W-1:0] font_id,
  input  wire logic [hcc_pkg::ITEM_W-1:0] item_id,
  output logic                            done,
  output logic [hcc_pkg::ITEM_W-1:0]      result_item,
  output logic [hcc_pkg::CTX_W-1:0]       result_context,
  output logic                            was_hit,
  output logic                            reprogram,
  output logic                            fault
);
  import hcc_pkg::*;

  logic [COLOR_W-1:0] key;
  logic [PIX_W-1:0]   pix;
  logic [SCR_W-1:0]   scr;
  logic [FN_W-1:0]    fn;
  logic               sub;
  logic [FONT_W-1:0]  font;
  logic [ITEM_W-1:0]  rel;

  logic [ITEM_W-1:0] slot_mem [ITEMS];
  logic [ITEMS-1:0]  slot_moved;
  logic [ITEM_W-1:0] slot_rd;
  logic [ITEM_W-1:0] slot_addr;
  logic [ITEM_W-1:0] slot_wdata;

  logic [CTX_W-1:0]   ictx_mem  [ITEMS];
  logic [USERS_W-1:0] users_mem [ITEMS];
  logic [HITS_W-1:0]  hits_mem  [ITEMS];
  logic [ITEMS-1:0]   has_ctx;
  logic [CTX_W-1:0]   ictx_rd;
  logic [USERS_W-1:0] users_rd;
  logic [HITS_W-1:0]  hits_rd;
  logic [ITEM_W-1:0]  item_raddr;

  logic [SCR_W-1:0]  scr_mem  [CONTEXTS];
  logic [PIX_W-1:0]  pix_mem  [CONTEXTS];
  logic [FN_W-1:0]   fn_mem   [CONTEXTS];
  logic              sub_mem  [CONTEXTS];
  logic [FONT_W-1:0] font_mem [CONTEXTS];
  logic [CONTEXTS-1:0] created;
  logic [CONTEXTS-1:0] busy_ctx;
  logic [SCR_W-1:0]  scr_rd;
  logic [PIX_W-1:0]  pix_rd;
  logic [FN_W-1:0]   fn_rd;
  logic              sub_rd;
  logic [FONT_W-1:0] font_rd;
  logic [CTX_W-1:0]  ctx_raddr;

  logic [ITEM_W-1:0]  it;
  logic [ITEM_W-1:0]  pv;
  logic [HITS_W-1:0]  hits_new;
  logic [USERS_W-1:0] users_inc;
  logic [HITS_W-1:0]  hits_inc;
  logic               font_chg;
  logic [CTX_W-1:0]   idx_ctx;
  logic [ITEM_W-1:0]  idx_item;
  logic               fill;
  logic [CTX_W-1:0]   fill_ctx;
  logic [ITEM_W-1:0]  item_waddr;

  assign idx_ctx    = cmd.idx[CTX_W-1:0];
  assign idx_item   = cmd.idx[ITEM_W-1:0];
  assign slot_addr  = {key[SET_W-1:0], cmd.slot_way};
  assign slot_wdata = cmd.slot_wsel_it ? it : pv;
  assign fill       = cmd.alloc_fill | cmd.reuse_fill;
  assign fill_ctx   = cmd.alloc_fill ? idx_ctx : ictx_rd;
  assign users_inc  = (users_rd == '1) ? users_rd : users_rd + USERS_W'(1);
  assign hits_inc   = (hits_rd == '1) ? hits_rd : hits_rd + HITS_W'(1);
  assign font_chg   = (font != '0) && (font != font_rd);
  assign item_waddr = cmd.rel_wr ? rel : it;
  assign ctx_raddr  = cmd.ctx_sel_idx ? idx_ctx : ictx_rd;

  always_comb begin
    unique case (cmd.item_sel)
      ISEL_SLOT: item_raddr = slot_rd;
      ISEL_REL:  item_raddr = rel;
      ISEL_IDX:  item_raddr = idx_item;
      default:   item_raddr = slot_rd;
    endcase
  end

  // request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key  <= red ^ green ^ blue;
      pix  <= pixel_value;
      scr  <= screen_number;
      fn   <= draw_function;
      sub  <= subwin_clip;
      font <= font_id;
      rel  <= item_id;
    end
    if (cmd.latch_it) it <= slot_rd;
    if (cmd.latch_pv) pv <= slot_rd;
    if (cmd.hit_wr) hits_new <= hits_inc;
  end

  // slot store, unmoved slots read as their own index
  always_ff @(posedge clk) begin
    if (cmd.slot_we) slot_mem[slot_addr] <= slot_wdata;
    if (cmd.slot_re) slot_rd <= slot_moved[slot_addr] ? slot_mem[slot_addr] : slot_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_moved <= '0;
    end else if (cmd.slot_we) begin
      slot_moved[slot_addr] <= 1'b1;
    end
  end

  // item store
  always_ff @(posedge clk) begin
    if (fill) ictx_mem[it] <= fill_ctx;
    if (cmd.item_re) ictx_rd <= ictx_mem[item_raddr];
  end

  always_ff @(posedge clk) begin
    if (fill) begin
      users_mem[item_waddr] <= USERS_W'(1);
    end else if (cmd.hit_wr) begin
      users_mem[item_waddr] <= users_inc;
    end else if (cmd.rel_wr) begin
      users_mem[item_waddr] <= users_rd - USERS_W'(1);
    end
    if (cmd.item_re) users_rd <= users_mem[item_raddr];
  end

  always_ff @(posedge clk) begin
    if (fill) begin
      hits_mem[it] <= HITS_W'(1);
    end else if (cmd.hit_wr) begin
      hits_mem[it] <= hits_inc;
    end
    if (cmd.item_re) hits_rd <= hits_mem[item_raddr];
  end

  // context store
  always_ff @(posedge clk) begin
    if (cmd.alloc_fill && !created[idx_ctx]) scr_mem[idx_ctx] <= scr;
    if (cmd.ctx_re) scr_rd <= scr_mem[ctx_raddr];
  end

  always_ff @(posedge clk) begin
    if (fill) begin
      pix_mem[fill_ctx] <= pix;
      fn_mem[fill_ctx]  <= fn;
      sub_mem[fill_ctx] <= sub;
    end
    if (cmd.ctx_re) begin
      pix_rd <= pix_mem[ctx_raddr];
      fn_rd  <= fn_mem[ctx_raddr];
      sub_rd <= sub_mem[ctx_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fill) begin
      font_mem[fill_ctx] <= font;
    end else if (cmd.hit_wr && font_chg) begin
      font_mem[ictx_rd] <= font;
    end
    if (cmd.ctx_re) font_rd <= font_mem[ctx_raddr];
  end

  // flags
  always_ff @(posedge clk) begin
    if (rst) begin
      has_ctx  <= '0;
      created  <= '0;
      busy_ctx <= '0;
    end else begin
      if (fill) begin
        has_ctx[it]        <= 1'b1;
        busy_ctx[fill_ctx] <= 1'b1;
      end
      if (cmd.alloc_fill) created[idx_ctx] <= 1'b1;
      if (cmd.purge_chk && has_ctx[idx_item] && users_rd == '0) begin
        has_ctx[idx_item] <= 1'b0;
        busy_ctx[ictx_rd] <= 1'b0;
      end
    end
  end

  always_comb begin
    status.has_ctx  = has_ctx[it];
    status.match    = (pix_rd == pix) && (fn_rd == fn) && (sub_rd == sub) && (scr_rd == scr);
    status.reuse_ok = (users_rd == '0) && (scr_rd == scr);
    status.free     = !created[idx_ctx] || (!busy_ctx[idx_ctx] && scr_rd == scr);
    status.promote  = hits_new > hits_rd;
    status.rel_ok   = has_ctx[rel] && (users_rd != '0);
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result_item    <= '0;
      result_context <= '0;
      was_hit        <= 1'b0;
      reprogram      <= 1'b0;
    end else if (fill) begin
      result_item    <= it;
      result_context <= fill_ctx;
      reprogram      <= 1'b1;
    end else if (cmd.hit_wr) begin
      result_item    <= it;
      result_context <= ictx_rd;
      was_hit        <= 1'b1;
      reprogram      <= font_chg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      fault <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        fault <= 1'b0;
      end else if (cmd.finish) begin
        fault <= cmd.fault;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/hcc_controller.sv @@
// controller: sequences probe, allocation scan, release and purge
// depends on hcc_pkg
`timescale 1ns / 1ps
`default_nettype none
module hcc_controller (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [hcc_pkg::CMD_W-1:0] command,
  output logic                           busy,
  output hcc_pkg::dp_cmd_t               cmd,
  input  wire hcc_pkg::dp_status_t       status
);
  import hcc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SLOT = 4'd1;
  localparam logic [3:0] S_ITEM = 4'd2;
  localparam logic [3:0] S_CTX  = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_PV   = 4'd5;
  localparam logic [3:0] S_PCMP = 4'd6;
  localparam logic [3:0] S_SW2  = 4'd7;
  localparam logic [3:0] S_ARD  = 4'd8;
  localparam logic [3:0] S_ACHK = 4'd9;
  localparam logic [3:0] S_RRD  = 4'd10;
  localparam logic [3:0] S_RWR  = 4'd11;
  localparam logic [3:0] S_PRD  = 4'd12;
  localparam logic [3:0] S_PCHK = 4'd13;

  localparam logic [WAY_W-1:0] WAY_LAST = WAY_W'(WAYS - 1);
  localparam logic [IDX_W-1:0] CTX_LAST = IDX_W'(CONTEXTS - 1);
  localparam logic [IDX_W-1:0] ITM_LAST = IDX_W'(ITEMS - 1);

  logic [3:0]       state, state_next;
  logic [WAY_W-1:0] way, way_next;
  logic [IDX_W-1:0] idx, idx_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      way   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      way   <= way_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    way_next   = way;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    cmd.slot_way = way;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          way_next = '0;
          idx_next = '0;
          unique case (command)
            CMD_FIND:    state_next = S_SLOT;
            CMD_RELEASE: state_next = S_RRD;
            CMD_PURGE:   state_next = S_PRD;
            default:     cmd.finish = 1'b1;
          endcase
        end
      end
      S_SLOT: begin
        cmd.slot_re = 1'b1;
        state_next  = S_ITEM;
      end
      S_ITEM: begin
        cmd.latch_it = 1'b1;
        cmd.item_re  = 1'b1;
        cmd.item_sel = ISEL_SLOT;
        state_next   = S_CTX;
      end
      S_CTX: begin
        if (status.has_ctx) begin
          cmd.ctx_re = 1'b1;
          state_next = S_CMP;
        end else begin
          idx_next   = '0;
          state_next = S_ARD;
        end
      end
      S_CMP: begin
        if (status.match) begin
          cmd.hit_wr = 1'b1;
          if (way == '0) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.slot_re  = 1'b1;
            cmd.slot_way = way - WAY_W'(1);
            state_next   = S_PV;
          end
        end else if (way == WAY_LAST) begin
          cmd.reuse_fill = status.reuse_ok;
          cmd.fault      = !status.reuse_ok;
          cmd.finish     = 1'b1;
          state_next     = S_IDLE;
        end else begin
          way_next   = way + WAY_W'(1);
          state_next = S_SLOT;
        end
      end
      S_PV: begin
        cmd.latch_pv = 1'b1;
        cmd.item_re  = 1'b1;
        cmd.item_sel = ISEL_SLOT;
        state_next   = S_PCMP;
      end
      S_PCMP: begin
        if (status.promote) begin
          cmd.slot_we = 1'b1;
          state_next  = S_SW2;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SW2: begin
        cmd.slot_we      = 1'b1;
        cmd.slot_wsel_it = 1'b1;
        cmd.slot_way     = way - WAY_W'(1);
        cmd.finish       = 1'b1;
        state_next       = S_IDLE;
      end
      S_ARD: begin
        cmd.ctx_re      = 1'b1;
        cmd.ctx_sel_idx = 1'b1;
        state_next      = S_ACHK;
      end
      S_ACHK: begin
        if (status.free) begin
          cmd.alloc_fill = 1'b1;
          cmd.finish     = 1'b1;
          state_next     = S_IDLE;
        end else if (idx == CTX_LAST) begin
          cmd.fault  = 1'b1;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = S_ARD;
        end
      end
      S_RRD: begin
        cmd.item_re  = 1'b1;
        cmd.item_sel = ISEL_REL;
        state_next   = S_RWR;
      end
      S_RWR: begin
        cmd.rel_wr = status.rel_ok;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_PRD: begin
        cmd.item_re  = 1'b1;
        cmd.item_sel = ISEL_IDX;
        state_next   = S_PCHK;
      end
      S_PCHK: begin
        cmd.purge_chk = 1'b1;
        if (idx == ITM_LAST) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = S_PRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/hashed_context_cache.sv @@
// top level of the hashed context cache
// depends on hcc_pkg, hcc_controller, hcc_datapath, hashed_context_cache_assert.svh
`timescale 1ns / 1ps
`default_nettype none
// A command is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high and cannot be held
// off, so the receiver must take it then. Busy stays high for the whole
// command: for each way probed that holds a context, a find reads the slot,
// item and context stores in turn, then compares; a hit may then read the
// slot before it and swap with it. A way found empty makes it scan the
// context records, reading and checking each, as it takes a context from
// the pool (up to 128). A release reads then writes the item, a purge reads
// and checks each item (128), and busy never rises for a no-op command.
// Done is high in the first cycle with busy low (the cycle after a no-op is
// taken). No clearing pass is needed after reset.
module hashed_context_cache (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [hcc_pkg::CMD_W-1:0]   command,
  input  wire logic [hcc_pkg::COLOR_W-1:0] red,
  input  wire logic [hcc_pkg::COLOR_W-1:0] green,
  input  wire logic [hcc_pkg::COLOR_W-1:0] blue,
  input  wire logic [hcc_pkg::PIX_W-1:0]   pixel_value,
  input  wire logic [hcc_pkg::SCR_W-1:0]   screen_number,
  input  wire logic [hcc_pkg::FN_W-1:0]    draw_function,
  input  wire logic                        subwin_clip,
  input  wire logic [hcc_pkg::FONT_W-1:0]  font_id,
  input  wire logic [hcc_pkg::ITEM_W-1:0]  item_id,
  output logic                             done,
  output logic [hcc_pkg::ITEM_W-1:0]       result_item,
  output logic [hcc_pkg::CTX_W-1:0]        result_context,
  output logic                             was_hit,
  output logic                             reprogram,
  output logic                             fault
);
  import hcc_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       result_clear;

  hcc_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .cmd     (dp_cmd),
    .status  (dp_status)
  );

  hcc_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (dp_cmd),
    .status         (dp_status),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .pixel_value    (pixel_value),
    .screen_number  (screen_number),
    .draw_function  (draw_function),
    .subwin_clip    (subwin_clip),
    .font_id        (font_id),
    .item_id        (item_id),
    .done           (done),
    .result_item    (result_item),
    .result_context (result_context),
    .was_hit        (was_hit),
    .reprogram      (reprogram),
    .fault          (fault)
  );

  assign result_clear = !was_hit && !reprogram && result_item == '0 && result_context == '0;

`include "hashed_context_cache_assert.svh"

  `HCC_ASSERT_NOW(a_fault_clean, done && fault, result_clear, "fault result carries data")
  `HCC_ASSERT_NEXT(a_start_busy, start && !busy && command != CMD_NOP, busy, "busy not raised")
  `HCC_ASSERT_NOW(a_done_idle, done, !busy || $past(busy) == 1'b0, "result while busy")
endmodule
`default_nettype wire
